// File: rtl/plk_pkg.sv
// Package for the panel link frame parser and reply queue.
// Holds the function codes, frame constants, handshake codes and the frame event struct.
// No dependencies; used by plk_frame and the top level.
package plk_pkg;

    // Function code of one input beat
    typedef enum logic [1:0] {
        FUNC_HOST_BYTE = 2'd0,
        FUNC_PULL      = 2'd1,
        FUNC_ENQUEUE   = 2'd2,
        FUNC_UNUSED    = 2'd3
    } t_func;

    // Frame layout: seven bytes, payloads at positions 2 and 4
    localparam logic [2:0] POS_FIRST_PAYLOAD  = 3'd2;
    localparam logic [2:0] POS_SECOND_PAYLOAD = 3'd4;
    localparam logic [2:0] POS_LAST           = 3'd6;

    // Handshake codes in the first payload
    localparam logic [7:0] HS_CODE_1F = 8'h1f;
    localparam logic [7:0] HS_CODE_1D = 8'h1d;
    localparam logic [7:0] HS_CODE_1E = 8'h1e;
    localparam logic [7:0] HS_CODE_20 = 8'h20;
    localparam logic [7:0] HS_CODE_E0 = 8'he0;
    localparam logic [7:0] HS_CODE_29 = 8'h29;
    localparam logic [7:0] HS_CODE_DD = 8'hdd;

    // Reply packet sent back on a handshake frame
    localparam logic [7:0] HS_REPLY_0 = 8'h18;
    localparam logic [7:0] HS_REPLY_1 = 8'h00;

    // LED address split of the first payload
    localparam logic [7:0] LED_BANK_MASK = 8'hc0;
    localparam logic [7:0] LED_REG_MASK  = 8'h3f;

    // Outcome of one host byte, seen by the top level
    typedef struct packed {
        logic       complete;   // this byte closes a frame
        logic       handshake;  // first payload is a handshake code
        logic       left_bank;
        logic [5:0] led_reg;
        logic [7:0] led_bits;
    } t_frame_evt;

    function automatic logic is_handshake(input logic [7:0] p);
        return (p == HS_CODE_1F) || (p == HS_CODE_1D) || (p == HS_CODE_1E) ||
               (p == HS_CODE_20) || (p == HS_CODE_E0) || (p == HS_CODE_29) ||
               (p == HS_CODE_DD);
    endfunction

endpackage

// File: rtl/plk_frame.sv
// Host frame parser: tracks the byte position in a frame and keeps both payloads.
// Depends on plk_pkg.
module plk_frame
    import plk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_en,   // a host byte beat is taken this cycle
    input  logic [7:0] i_tx_data,
    output t_frame_evt o_evt
);

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [7:0] r_first;
    logic [7:0] n_first;
    logic [7:0] r_second;
    logic [7:0] n_second;

    // Position and payload capture
    always_comb begin
        n_pos    = r_pos;
        n_first  = r_first;
        n_second = r_second;
        if (i_byte_en) begin
            if (r_pos == POS_FIRST_PAYLOAD) begin
                n_first = i_tx_data;
            end else if (r_pos == POS_SECOND_PAYLOAD) begin
                n_second = i_tx_data;
            end
            // out-of-range positions also close the frame
            if (r_pos >= POS_LAST) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_first  <= '0;
            r_second <= '0;
        end else begin
            r_pos    <= n_pos;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // Frame end event from the stored payloads
    always_comb begin
        o_evt.complete  = i_byte_en && (r_pos >= POS_LAST);
        o_evt.handshake = is_handshake(r_first);
        o_evt.left_bank = |(r_first & LED_BANK_MASK);
        o_evt.led_reg   = 6'(r_first & LED_REG_MASK);
        o_evt.led_bits  = r_second;
    end

endmodule

// File: rtl/panel_link_frame_and_reply_queue_top.sv
// Top level of the panel link: host frame parsing, reply packet queue, result staging.
// Depends on plk_pkg and plk_frame.
//
// One beat in, one result beat out, one beat per clock sustained while the result
// channel does not stall. Each beat is decoded and applied to the frame parser
// and reply queue in the cycle it is taken; the reply memory read is registered,
// and a result passes through stage A and then the output register. A result
// stage and the output register sit between the channels, so a new beat is taken
// while a result waits to be collected. Reply packets are stored two bytes to a
// memory row, written once per packet; the queue is rewound only when fully
// drained, and a packet that does not fit in REPLY_DEPTH bytes is dropped and
// flagged. The reply memory needs no clearing after reset.
module panel_link_frame_and_reply_queue_top
    import plk_pkg::*;
#(
    parameter int REPLY_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_tx_data,
    input  logic [7:0] i_packet_addr,
    input  logic [7:0] i_packet_data,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_led_valid,
    output logic       o_led_left_bank,
    output logic [5:0] o_led_register,
    output logic [7:0] o_led_bits,
    output logic       o_attention,
    output logic       o_packet_dropped,
    output logic       o_reply_valid,
    output logic [7:0] o_reply_byte
);

    localparam int ROWS = REPLY_DEPTH / 2;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW   = $clog2(REPLY_DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(REPLY_DEPTH);

    // Handshake between the stages
    logic in_acc;
    logic a_adv;
    logic out_acc;
    t_func func;

    // Stage A: result fields of the most recently taken beat
    logic       r_a_valid;
    logic       r_a_led_valid;
    logic       r_a_left;
    logic [5:0] r_a_reg;
    logic [7:0] r_a_bits;
    logic       r_a_attn;
    logic       r_a_drop;
    logic       r_a_rvalid;
    logic       r_a_bsel;
    logic [15:0] r_mem_q;

    // Output register
    logic       r_b_valid;
    logic       r_b_led_valid;
    logic       r_b_left;
    logic [5:0] r_b_reg;
    logic [7:0] r_b_bits;
    logic       r_b_attn;
    logic       r_b_drop;
    logic       r_b_rvalid;
    logic [7:0] r_b_byte;

    // Queue pointers
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;
    logic [CW-1:0] r_read;
    logic [CW-1:0] n_read;

    logic [15:0] mem [ROWS];

    t_frame_evt evt;
    logic       byte_en;
    logic       enq;
    logic [7:0] enq_b0;
    logic [7:0] enq_b1;
    logic       drained;
    logic [CW-1:0] eff_fill;
    logic       drop;
    logic       attn;
    logic       pull_hit;
    logic       led_hit;

    assign func       = t_func'(i_func);
    assign a_adv      = r_a_valid && (!r_b_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !a_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_b_valid && !i_out_stall;
    assign byte_en    = in_acc && (func == FUNC_HOST_BYTE);

    plk_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_tx_data (i_tx_data),
        .o_evt     (evt)
    );

    // Queue control: enqueue, rewind, drop, pull
    always_comb begin
        enq      = 1'b0;
        enq_b0   = i_packet_addr;
        enq_b1   = i_packet_data;
        led_hit  = 1'b0;
        if (in_acc) begin
            unique case (func)
                FUNC_HOST_BYTE: begin
                    if (evt.complete) begin
                        enq     = evt.handshake;
                        led_hit = !evt.handshake;
                        enq_b0  = HS_REPLY_0;
                        enq_b1  = HS_REPLY_1;
                    end
                end
                FUNC_ENQUEUE: enq = 1'b1;
                default: ;
            endcase
        end
        drained  = (r_read == r_fill);
        eff_fill = drained ? '0 : r_fill;
        drop     = enq && (({1'b0, eff_fill} + (CW + 1)'(2)) > DEPTH_W);
        attn     = enq && !drop && drained;
        pull_hit = in_acc && (func == FUNC_PULL) && (r_read < r_fill);

        n_fill = r_fill;
        n_read = r_read;
        if (enq) begin
            if (drained) begin
                n_read = '0;
            end
            n_fill = drop ? eff_fill : eff_fill + CW'(2);
        end else if (pull_hit) begin
            n_read = r_read + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_read <= '0;
        end else begin
            r_fill <= n_fill;
            r_read <= n_read;
        end
    end

    // Reply memory: one packet per row, registered read on a pull beat
    always_ff @(posedge i_clk) begin
        if (enq && !drop) begin
            mem[eff_fill[RW:1]] <= {enq_b1, enq_b0};
        end
        if (in_acc && func == FUNC_PULL) begin
            r_mem_q <= mem[r_read[RW:1]];
        end
    end

    // Stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_led_valid <= led_hit;
            r_a_left      <= led_hit && evt.left_bank;
            r_a_reg       <= led_hit ? evt.led_reg : '0;
            r_a_bits      <= led_hit ? evt.led_bits : '0;
            r_a_attn      <= attn;
            r_a_drop      <= drop;
            r_a_rvalid    <= pull_hit;
            r_a_bsel      <= r_read[0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (out_acc) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_led_valid <= r_a_led_valid;
            r_b_left      <= r_a_left;
            r_b_reg       <= r_a_reg;
            r_b_bits      <= r_a_bits;
            r_b_attn      <= r_a_attn;
            r_b_drop      <= r_a_drop;
            r_b_rvalid    <= r_a_rvalid;
            if (!r_a_rvalid) begin
                r_b_byte <= '0;
            end else if (r_a_bsel) begin
                r_b_byte <= r_mem_q[15:8];
            end else begin
                r_b_byte <= r_mem_q[7:0];
            end
        end
    end

    assign o_out_valid      = r_b_valid;
    assign o_led_valid      = r_b_led_valid;
    assign o_led_left_bank  = r_b_left;
    assign o_led_register   = r_b_reg;
    assign o_led_bits       = r_b_bits;
    assign o_attention      = r_b_attn;
    assign o_packet_dropped = r_b_drop;
    assign o_reply_valid    = r_b_rvalid;
    assign o_reply_byte     = r_b_byte;

endmodule

// File: tb/sv/tb_panel_link_frame_and_reply_queue_top.sv
// Self-checking testbench for panel_link_frame_and_reply_queue_top.
// Drives host bytes, pulls and packet enqueues and checks each result beat
// against a cycle-free predictor. Depends on plk_pkg and the top level RTL.
`timescale 1ns / 100ps

module tb_panel_link_frame_and_reply_queue_top;
    import plk_pkg::*;

    localparam int REPLY_DEPTH  = 32;
    localparam int FRAME_LEN    = 7;
    localparam int RANDOM_ITEMS = 1600;
    localparam int SEG_ITEMS    = 100;
    localparam int HOLD_CYCLES  = 120;
    localparam int TAIL_CYCLES  = 20;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam logic [7:0] HS_CODES [7] = '{HS_CODE_1F, HS_CODE_1D, HS_CODE_1E,
        HS_CODE_20, HS_CODE_E0, HS_CODE_29, HS_CODE_DD};

    // Flow-control phases, cycled through the random part
    typedef enum logic [2:0] {
        PH_FREE        = 3'd0,
        PH_SEND_IDLE   = 3'd1,
        PH_RECV_STALL  = 3'd2,
        PH_BOTH        = 3'd3,
        PH_LONG_HOLD   = 3'd4
    } tb_phase_e;

    typedef struct packed {
        t_func      func;
        logic [7:0] tx_data;
        logic [7:0] packet_addr;
        logic [7:0] packet_data;
        tb_phase_e  phase;
        logic       drain;      // wait for all results before offering this beat
    } host_item_t;

    typedef struct packed {
        logic       led_valid;
        logic       led_left_bank;
        logic [5:0] led_register;
        logic [7:0] led_bits;
        logic       attention;
        logic       packet_dropped;
        logic       reply_valid;
        logic [7:0] reply_byte;
    } panel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    host_item_t offer = '0;
    tb_phase_e cur_phase = PH_FREE;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_led_valid;
    logic       o_led_left_bank;
    logic [5:0] o_led_register;
    logic [7:0] o_led_bits;
    logic       o_attention;
    logic       o_packet_dropped;
    logic       o_reply_valid;
    logic [7:0] o_reply_byte;

    host_item_t    host_beats[$];
    panel_result_t expected_results[$];
    int            fail_count = 0;

    // Predictor state
    logic [2:0] frame_pos = '0;
    logic [7:0] pay_first = '0;
    logic [7:0] pay_second = '0;
    logic [7:0] reply_mem [REPLY_DEPTH];
    int unsigned reply_wr = 0;
    int unsigned reply_rd = 0;

    // Stimulus generation state
    int  gen_pos = 0;
    int  rand_count = 0;
    bit  in_random = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    panel_link_frame_and_reply_queue_top #(
        .REPLY_DEPTH(REPLY_DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (offer.func),
        .i_tx_data       (offer.tx_data),
        .i_packet_addr   (offer.packet_addr),
        .i_packet_data   (offer.packet_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_led_valid     (o_led_valid),
        .o_led_left_bank (o_led_left_bank),
        .o_led_register  (o_led_register),
        .o_led_bits      (o_led_bits),
        .o_attention     (o_attention),
        .o_packet_dropped(o_packet_dropped),
        .o_reply_valid   (o_reply_valid),
        .o_reply_byte    (o_reply_byte)
    );

    // Append a reply packet; returns {dropped, attention}
    function automatic logic [1:0] queue_packet(input logic [7:0] b0, input logic [7:0] b1);
        logic was_empty;
        if (reply_rd == reply_wr) begin
            reply_rd = 0;
            reply_wr = 0;
        end
        if (reply_wr + 2 > REPLY_DEPTH) return 2'b10;
        was_empty = (reply_rd == reply_wr);
        reply_mem[reply_wr]     = b0;
        reply_mem[reply_wr + 1] = b1;
        reply_wr += 2;
        return {1'b0, was_empty};
    endfunction

    // Expected result of one accepted beat; advances the predictor state
    function automatic panel_result_t panel_step(input host_item_t it);
        panel_result_t r;
        logic [1:0] q;
        r = '0;
        case (it.func)
            FUNC_HOST_BYTE: begin
                if (frame_pos == POS_FIRST_PAYLOAD) pay_first = it.tx_data;
                else if (frame_pos == POS_SECOND_PAYLOAD) pay_second = it.tx_data;
                if (frame_pos >= POS_LAST) begin
                    frame_pos = '0;
                    if (pay_first inside {HS_CODE_1F, HS_CODE_1D, HS_CODE_1E, HS_CODE_20,
                                          HS_CODE_E0, HS_CODE_29, HS_CODE_DD}) begin
                        q = queue_packet(HS_REPLY_0, HS_REPLY_1);
                        r.packet_dropped = q[1];
                        r.attention      = q[0];
                    end else begin
                        r.led_valid     = 1'b1;
                        r.led_left_bank = (pay_first & LED_BANK_MASK) != 8'h00;
                        r.led_register  = 6'(pay_first & LED_REG_MASK);
                        r.led_bits      = pay_second;
                    end
                end else begin
                    frame_pos = frame_pos + 3'd1;
                end
            end
            FUNC_PULL: begin
                if (reply_rd < reply_wr && reply_rd < REPLY_DEPTH) begin
                    r.reply_valid = 1'b1;
                    r.reply_byte  = reply_mem[reply_rd];
                    reply_rd++;
                end
            end
            FUNC_ENQUEUE: begin
                q = queue_packet(it.packet_addr, it.packet_data);
                r.packet_dropped = q[1];
                r.attention      = q[0];
            end
            default: ;  // unused code: all-zero result, no state change
        endcase
        return r;
    endfunction

    function automatic bit roll_pct(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic push_item(input t_func f, input logic [7:0] tx,
                             input logic [7:0] pa, input logic [7:0] pd);
        host_item_t it;
        it.func        = f;
        it.tx_data     = tx;
        it.packet_addr = pa;
        it.packet_data = pd;
        it.phase       = in_random ? tb_phase_e'((rand_count / SEG_ITEMS) % 5) : PH_FREE;
        it.drain       = in_random && (rand_count % SEG_ITEMS == 0);
        host_beats.push_back(it);
        if (f == FUNC_HOST_BYTE) gen_pos = (gen_pos + 1) % FRAME_LEN;
        if (in_random) rand_count++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Input driver: offers the next pending beat, predicts on acceptance
    always @(posedge clk) begin
        host_item_t nxt;
        bit take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && !o_in_stall;
            if (take) expected_results.push_back(panel_step(offer));
            if (take || !in_valid) begin
                if (host_beats.size() != 0
                    && !(host_beats[0].drain && expected_results.size() != 0)
                    && !(host_beats[0].phase == PH_SEND_IDLE && roll_pct(70))
                    && !(host_beats[0].phase == PH_BOTH && roll_pct(26))) begin
                    nxt = host_beats.pop_front();
                    offer     <= nxt;
                    in_valid  <= 1'b1;
                    cur_phase <= nxt.phase;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result side stall: random per phase, plus one long hold per hold segment
    int  hold_left = 0;
    bit  hold_armed = 1'b1;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && cur_phase == PH_LONG_HOLD) begin
            hold_armed <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end else begin
            if (cur_phase != PH_LONG_HOLD) hold_armed <= 1'b1;
            out_stall <= (cur_phase == PH_RECV_STALL && roll_pct(70))
                      || (cur_phase == PH_BOTH && roll_pct(26));
        end
    end

    // Result monitor: compare each taken beat with the oldest expectation
    always @(posedge clk) begin
        panel_result_t want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: result beat with nothing expected, led %0b reply %0b byte %0h",
                         $time, o_led_valid, o_reply_valid, o_reply_byte);
            end else begin
                want = expected_results.pop_front();
                check_field("led_valid", want.led_valid, o_led_valid);
                check_field("led_left_bank", want.led_left_bank, o_led_left_bank);
                check_field("led_register", want.led_register, o_led_register);
                check_field("led_bits", want.led_bits, o_led_bits);
                check_field("attention", want.attention, o_attention);
                check_field("packet_dropped", want.packet_dropped, o_packet_dropped);
                check_field("reply_valid", want.reply_valid, o_reply_valid);
                check_field("reply_byte", want.reply_byte, o_reply_byte);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int kind;
        int len;
        logic [7:0] b;

        // Directed: empty pull, unused code, LED frame, handshake frame, queue drain/rewind
        push_item(FUNC_PULL, 8'hff, 8'hff, 8'hff);
        push_item(FUNC_UNUSED, 8'hff, 8'hff, 8'hff);
        push_item(FUNC_UNUSED, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_HOST_BYTE, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_HOST_BYTE, 8'hff, 8'h00, 8'h00);
        push_item(FUNC_HOST_BYTE, 8'h3f, 8'h00, 8'h00);   // right bank, register 63
        push_item(FUNC_HOST_BYTE, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_HOST_BYTE, 8'hff, 8'h00, 8'h00);   // all LEDs lit
        push_item(FUNC_HOST_BYTE, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_HOST_BYTE, 8'h55, 8'h00, 8'h00);
        push_item(FUNC_HOST_BYTE, 8'h00, 8'hff, 8'hff);
        push_item(FUNC_HOST_BYTE, 8'h00, 8'hff, 8'hff);
        push_item(FUNC_HOST_BYTE, HS_CODE_DD, 8'hff, 8'hff);  // handshake frame
        push_item(FUNC_HOST_BYTE, 8'h00, 8'hff, 8'hff);
        push_item(FUNC_HOST_BYTE, 8'h00, 8'hff, 8'hff);
        push_item(FUNC_HOST_BYTE, 8'h00, 8'hff, 8'hff);
        push_item(FUNC_HOST_BYTE, 8'hff, 8'hff, 8'hff);
        push_item(FUNC_PULL, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_ENQUEUE, 8'h00, 8'hff, 8'hff);     // into non-empty buffer
        push_item(FUNC_PULL, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_PULL, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_PULL, 8'h00, 8'h00, 8'h00);
        push_item(FUNC_PULL, 8'h00, 8'h00, 8'h00);        // drained: empty pull
        push_item(FUNC_ENQUEUE, 8'hff, 8'h00, 8'h00);     // rewind, attention
        push_item(FUNC_PULL, 8'h00, 8'h00, 8'h00);

        // Random sequences: host byte runs, enqueue bursts, pull bursts, noise
        in_random = 1'b1;
        while (rand_count < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                len = $urandom_range(1, 2 * FRAME_LEN);
                repeat (len) begin
                    b = (gen_pos == POS_FIRST_PAYLOAD && roll_pct(45))
                        ? HS_CODES[$urandom_range(0, 6)] : 8'($urandom);
                    push_item(FUNC_HOST_BYTE, b, 8'($urandom), 8'($urandom));
                end
            end else if (kind <= 5) begin
                len = $urandom_range(1, 18);
                repeat (len) push_item(FUNC_ENQUEUE, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (kind <= 7) begin
                len = $urandom_range(1, 20);
                repeat (len) push_item(FUNC_PULL, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (kind == 8) begin
                len = $urandom_range(1, 3);
                repeat (len) push_item(FUNC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) push_item(t_func'($urandom_range(0, 3)), 8'($urandom),
                                       8'($urandom), 8'($urandom));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (host_beats.size() != 0 || in_valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("panel_link_frame_and_reply_queue_top test passed");
        end else begin
            $display("panel_link_frame_and_reply_queue_top test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("panel_link_frame_and_reply_queue_top test failed");
        $finish;
    end

endmodule
